[rtl/core/mjd_pkg.sv]
// Shared types, constants and the sigmoid table of the jump decision network.
`timescale 1ns / 1ps
`default_nettype none
package mjd_pkg;

    localparam int FEAT_W = 16;
    localparam int WGT_W = 16;
    localparam int ACT_W = 16;
    localparam int SIG_ENTRIES = 256;
    localparam int SIG_IDX_W = 8;
    localparam logic [15:0] THRESHOLD_RESET = 16'd38011;
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748381;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    localparam logic CFG_REG_THRESHOLD = 1'b0;

    typedef logic [ACT_W-1:0] t_sig_arr [SIG_ENTRIES];

    // Restoring long division, used only while the table is built at elaboration.
    function automatic logic [63:0] div_u64(logic [63:0] n, logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry i holds sigmoid(-8 + i/16) in Q0.16, built from a rounded power series of e^(-1/16).
    function automatic t_sig_arr build_sig_table();
        logic [63:0] pw [129];
        logic [63:0] t;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] v;
        t_sig_arr tab;
        pw[0] = 64'd1 << 32;
        for (int k = 1; k <= 128; k++) begin
            pw[k] = (pw[k-1] * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
        end
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            t = (i >= 128) ? pw[i-128] : pw[128-i];
            den = (64'd1 << 32) + t;
            num = (i >= 128) ? (64'd1 << 48) : (t << 16);
            v = div_u64(num + (den >> 1), den);
            tab[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
        end
        return tab;
    endfunction

    localparam t_sig_arr SIG_TABLE = build_sig_table();

endpackage
`default_nettype wire

[rtl/core/mjd_if.sv]
// Request and result channel interfaces of the jump decision network.
`timescale 1ns / 1ps
`default_nettype none
interface mjd_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [4:0]         weight_index;
    logic signed [15:0] weight_value;
    logic [9:0]         bird_height;
    logic [9:0]         gap_height;
    logic signed [11:0] gap_x;

    modport source (output valid, req_type, weight_index, weight_value, bird_height,
                    gap_height, gap_x, input ready);
    modport sink (input valid, req_type, weight_index, weight_value, bird_height,
                  gap_height, gap_x, output ready);
endinterface

interface mjd_res_if;
    logic        valid;
    logic        ready;
    logic        jump;
    logic [15:0] activation;

    modport source (output valid, jump, activation, input ready);
    modport sink (input valid, jump, activation, output ready);
endinterface
`default_nettype wire

[rtl/core/mjd_feature.sv]
// Three-stage feature normalization: reciprocal multiply, remainder correction, saturation.
`timescale 1ns / 1ps
`default_nettype none
module mjd_feature #(
    parameter int SCREEN_HEIGHT = 1024,
    parameter int SCREEN_WIDTH = 1024,
    parameter int BIRD_COLUMN = 128
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic [9:0]                          i_bird_height,
    input  wire logic [9:0]                          i_gap_height,
    input  wire logic signed [11:0]                  i_gap_x,
    output logic                                     o_valid,
    output logic                                     o_busy,
    output logic signed [mjd_pkg::FEAT_W-1:0]        o_feat [3]
);
    localparam int RSH = 28;
    localparam int unsigned DIV [3] = '{SCREEN_HEIGHT, SCREEN_HEIGHT, SCREEN_WIDTH};
    localparam int unsigned RECIP [3] = '{(2**RSH) / SCREEN_HEIGHT,
                                          (2**RSH) / SCREEN_HEIGHT,
                                          (2**RSH) / SCREEN_WIDTH};

    logic signed [13:0] num [3];
    logic        [13:0] absn [3];
    logic        [27:0] n_a [3];
    logic        [27:0] r1_a [3];
    logic               r1_neg [3];
    logic               r1_valid;
    logic        [50:0] prod [3];
    logic        [22:0] r2_q [3];
    logic        [27:0] r2_a [3];
    logic               r2_neg [3];
    logic               r2_valid;
    logic        [35:0] rem [3];
    logic        [22:0] qfix [3];
    logic signed [mjd_pkg::FEAT_W-1:0] n_feat [3];
    logic signed [mjd_pkg::FEAT_W-1:0] r3_feat [3];
    logic               r3_valid;

    always_comb begin
        num[0] = $signed({4'b0, i_bird_height});
        num[1] = $signed({4'b0, i_gap_height}) - $signed({4'b0, i_bird_height});
        num[2] = $signed({{2{i_gap_x[11]}}, i_gap_x}) - $signed(14'(BIRD_COLUMN));
        for (int k = 0; k < 3; k++) begin
            absn[k] = num[k][13] ? 14'(-num[k]) : 14'(num[k]);
            // Floor of a negative quotient is the negated ceiling of the magnitude.
            n_a[k] = (28'(absn[k]) << 15) + (num[k][13] ? 28'(DIV[k] - 1) : 28'd0);
            prod[k] = 51'(r1_a[k]) * 51'(RECIP[k]);
            rem[k] = 36'(r2_a[k]) - 36'(r2_q[k]) * 36'(DIV[k]);
            qfix[k] = r2_q[k] + ((rem[k] >= 36'(DIV[k])) ? 23'd1 : 23'd0);
            if (r2_neg[k]) begin
                n_feat[k] = (qfix[k] > 23'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, qfix[k]}));
            end else begin
                n_feat[k] = (qfix[k] > 23'd32767) ? 16'sh7FFF : 16'(qfix[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_a[k] <= n_a[k];
                r1_neg[k] <= num[k][13];
                r2_q[k] <= prod[k][50:28];
                r2_a[k] <= r1_a[k];
                r2_neg[k] <= r1_neg[k];
                r3_feat[k] <= n_feat[k];
            end
        end
    end

    assign o_valid = r3_valid;
    assign o_busy = r1_valid | r2_valid | r3_valid;
    assign o_feat = r3_feat;
endmodule
`default_nettype wire

[rtl/core/mjd_hidden.sv]
// Hidden layer: product lanes, per-unit sum and table index, sigmoid lookup.
`timescale 1ns / 1ps
`default_nettype none
module mjd_hidden #(
    parameter int HIDDEN_UNITS = 6
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic                                 i_valid,
    input  wire logic signed [mjd_pkg::FEAT_W-1:0]    i_feat [3],
    input  wire logic signed [mjd_pkg::WGT_W-1:0]     i_w_ih [3*HIDDEN_UNITS],
    output logic                                      o_valid,
    output logic                                      o_busy,
    output logic [mjd_pkg::ACT_W-1:0]                 o_hid [HIDDEN_UNITS]
);
    logic signed [31:0] r4_p [3][HIDDEN_UNITS];
    logic               r4_valid;
    logic signed [33:0] z [HIDDEN_UNITS];
    logic signed [10:0] zt [HIDDEN_UNITS];
    logic [mjd_pkg::SIG_IDX_W-1:0] n_idx [HIDDEN_UNITS];
    logic [mjd_pkg::SIG_IDX_W-1:0] r5_idx [HIDDEN_UNITS];
    logic               r5_valid;
    logic [mjd_pkg::ACT_W-1:0] r6_h [HIDDEN_UNITS];
    logic               r6_valid;

    always_comb begin
        for (int u = 0; u < HIDDEN_UNITS; u++) begin
            z[u] = 34'(r4_p[0][u]) + 34'(r4_p[1][u]) + 34'(r4_p[2][u]);
            zt[u] = z[u][33:23];
            if (zt[u] < -11'sd128) begin
                n_idx[u] = 8'd0;
            end else if (zt[u] > 11'sd127) begin
                n_idx[u] = 8'd255;
            end else begin
                n_idx[u] = 8'(zt[u] + 11'sd128);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int u = 0; u < HIDDEN_UNITS; u++) begin
                for (int i = 0; i < 3; i++) begin
                    r4_p[i][u] <= i_feat[i] * i_w_ih[i*HIDDEN_UNITS + u];
                end
                r5_idx[u] <= n_idx[u];
                r6_h[u] <= mjd_pkg::SIG_TABLE[r5_idx[u]];
            end
        end
    end

    assign o_valid = r6_valid;
    assign o_busy = r4_valid | r5_valid | r5_valid | r6_valid;
    assign o_hid = r6_h;
endmodule
`default_nettype wire

[rtl/core/mjd_output.sv]
// Output layer: weighted products, sum, division by the unit count, sigmoid and threshold.
`timescale 1ns / 1ps
`default_nettype none
module mjd_output #(
    parameter int HIDDEN_UNITS = 6
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic [mjd_pkg::ACT_W-1:0]           i_hid [HIDDEN_UNITS],
    input  wire logic signed [mjd_pkg::WGT_W-1:0]    i_w_ho [HIDDEN_UNITS],
    input  wire logic [15:0]                         i_threshold,
    output logic                                     o_valid,
    output logic                                     o_busy,
    output logic                                     o_jump,
    output logic [mjd_pkg::ACT_W-1:0]                o_activation
);
    localparam int AW = 33 + $clog2(HIDDEN_UNITS) + 1;
    localparam int TW = AW - 24;
    localparam int QW = TW + 1;
    localparam int unsigned RECIP = (2**16) / HIDDEN_UNITS;

    logic signed [32:0] r7_p [HIDDEN_UNITS];
    logic               r7_valid;
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] r8_acc;
    logic               r8_valid;
    logic signed [TW-1:0] t;
    logic        [QW-1:0] a;
    logic        [QW+16:0] qprod;
    logic        [QW-1:0] r9_a;
    logic        [QW-1:0] r9_q;
    logic               r9_neg;
    logic               r9_valid;
    logic        [QW+5:0] rem;
    logic        [QW:0]   qfix;
    logic [mjd_pkg::SIG_IDX_W-1:0] n_idx;
    logic [mjd_pkg::SIG_IDX_W-1:0] r10_idx;
    logic               r10_valid;
    logic [mjd_pkg::ACT_W-1:0] act;
    logic [mjd_pkg::ACT_W-1:0] r11_act;
    logic               r11_jump;
    logic               r11_valid;

    always_comb begin
        acc = '0;
        for (int u = 0; u < HIDDEN_UNITS; u++) begin
            acc = acc + AW'(r7_p[u]);
        end
        t = r8_acc[AW-1:24];
        // Floor division by the unit count works on the magnitude, biased when negative.
        a = t[TW-1] ? QW'(-$signed({t[TW-1], t}) + (HIDDEN_UNITS - 1)) : QW'(t);
        qprod = (QW+17)'(a) * (QW+17)'(RECIP);
        rem = (QW+6)'(r9_a) - (QW+6)'(r9_q) * (QW+6)'(HIDDEN_UNITS);
        qfix = (QW+1)'(r9_q) + ((rem >= (QW+6)'(HIDDEN_UNITS)) ? (QW+1)'(1) : (QW+1)'(0));
        if (r9_neg) begin
            n_idx = (qfix > (QW+1)'(128)) ? 8'd0 : 8'((QW+1)'(128) - qfix);
        end else begin
            n_idx = (qfix > (QW+1)'(127)) ? 8'd255 : 8'(qfix + (QW+1)'(128));
        end
        act = mjd_pkg::SIG_TABLE[r10_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
            r9_valid <= 1'b0;
            r10_valid <= 1'b0;
            r11_valid <= 1'b0;
        end else if (i_en) begin
            r7_valid <= i_valid;
            r8_valid <= r7_valid;
            r9_valid <= r8_valid;
            r10_valid <= r9_valid;
            r11_valid <= r10_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int u = 0; u < HIDDEN_UNITS; u++) begin
                r7_p[u] <= $signed({1'b0, i_hid[u]}) * i_w_ho[u];
            end
            r8_acc <= acc;
            r9_a <= a;
            r9_q <= qprod[QW+15:16];
            r9_neg <= t[TW-1];
            r10_idx <= n_idx;
            r11_act <= act;
            r11_jump <= (act < i_threshold);
        end
    end

    assign o_valid = r11_valid;
    assign o_busy = r7_valid | r8_valid | r9_valid | r10_valid | r11_valid;
    assign o_jump = r11_jump;
    assign o_activation = r11_act;
endmodule
`default_nettype wire

[rtl/core/mlp_jump_decision_unit.sv]
// Top level of the 3-hidden-1 perceptron that decides whether the bird jumps.
// Usage: requests arrive on i_req (valid/ready). A load item (req_type 0) writes
// weight_value into slot weight_index of the weight store; slots 0 to 3*H-1 are
// feature-to-hidden weights (feature*H + unit) and slots 3*H to 4*H-1 are
// hidden-to-output weights. A load to a slot past the store is dropped and no
// load ever produces a result. An evaluate item (req_type 1) gives one result
// on o_res carrying the output activation (Q0.16) and the jump flag.
// The block takes one evaluate item per cycle while the receiver does not
// stall, the pipeline being eleven register stages with the last one serving
// as the output register. When the receiver stalls, the whole pipeline holds.
// A load item is taken only while no evaluate item is in flight, so it waits
// for the pipeline to drain.
// Reset (synchronous, active low) empties the pipeline and sets the jump
// threshold to 0.58; the weight store is not cleared and must be loaded fully
// before evaluating. The threshold register sits at APB address 0; the user
// must write it only while idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module mlp_jump_decision_unit #(
    parameter int SCREEN_HEIGHT = 1024,
    parameter int SCREEN_WIDTH = 1024,
    parameter int BIRD_COLUMN = 128,
    parameter int HIDDEN_UNITS = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mjd_req_if.sink          i_req,
    mjd_res_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int STORE_DEPTH = 4 * HIDDEN_UNITS;

    logic signed [mjd_pkg::WGT_W-1:0] r_weights [STORE_DEPTH];
    logic signed [mjd_pkg::WGT_W-1:0] w_ih [3*HIDDEN_UNITS];
    logic signed [mjd_pkg::WGT_W-1:0] w_ho [HIDDEN_UNITS];
    logic [15:0] r_threshold;
    logic        en;
    logic        busy;
    logic        accept;
    logic        feat_valid;
    logic        feat_busy;
    logic signed [mjd_pkg::FEAT_W-1:0] feat [3];
    logic        hid_valid;
    logic        hid_busy;
    logic [mjd_pkg::ACT_W-1:0] hid [HIDDEN_UNITS];
    logic        out_valid;
    logic        out_busy;

    // The whole pipeline advances together whenever the output register can move.
    assign en = !out_valid || o_res.ready;
    assign busy = feat_busy | hid_busy | out_busy;
    // A load must not change weights under an evaluate item still in flight.
    assign i_req.ready = en && !((i_req.req_type == mjd_pkg::REQ_LOAD) && busy);
    assign accept = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (accept && (i_req.req_type == mjd_pkg::REQ_LOAD)) begin
            for (int j = 0; j < STORE_DEPTH; j++) begin
                if (32'(i_req.weight_index) == j) begin
                    r_weights[j] <= i_req.weight_value;
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3*HIDDEN_UNITS; j++) begin
            w_ih[j] = r_weights[j];
        end
        for (int u = 0; u < HIDDEN_UNITS; u++) begin
            w_ho[u] = r_weights[3*HIDDEN_UNITS + u];
        end
    end

    // Configuration port: one register, written on the APB access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= mjd_pkg::THRESHOLD_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == mjd_pkg::CFG_REG_THRESHOLD)) begin
            r_threshold <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mjd_pkg::CFG_REG_THRESHOLD) ? {16'b0, r_threshold} : 32'b0;

    mjd_feature #(
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .SCREEN_WIDTH(SCREEN_WIDTH),
        .BIRD_COLUMN(BIRD_COLUMN)
    ) u_feature (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_en(en),
        .i_valid(accept && (i_req.req_type == mjd_pkg::REQ_EVAL)),
        .i_bird_height(i_req.bird_height),
        .i_gap_height(i_req.gap_height),
        .i_gap_x(i_req.gap_x),
        .o_valid(feat_valid),
        .o_busy(feat_busy),
        .o_feat(feat)
    );

    mjd_hidden #(
        .HIDDEN_UNITS(HIDDEN_UNITS)
    ) u_hidden (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_en(en),
        .i_valid(feat_valid),
        .i_feat(feat),
        .i_w_ih(w_ih),
        .o_valid(hid_valid),
        .o_busy(hid_busy),
        .o_hid(hid)
    );

    mjd_output #(
        .HIDDEN_UNITS(HIDDEN_UNITS)
    ) u_output (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_en(en),
        .i_valid(hid_valid),
        .i_hid(hid),
        .i_w_ho(w_ho),
        .i_threshold(r_threshold),
        .o_valid(out_valid),
        .o_busy(out_busy),
        .o_jump(o_res.jump),
        .o_activation(o_res.activation)
    );

    assign o_res.valid = out_valid;
endmodule
`default_nettype wire

[rtl/core/mjd_checker.sv]
// Port-level assertions for the jump decision unit and their binding.
`timescale 1ns / 1ps
`default_nettype none
module mjd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_req_type,
    input wire logic        i_res_valid,
    input wire logic        i_res_ready,
    input wire logic        i_res_jump,
    input wire logic [15:0] i_res_activation
);
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_activation) && $stable(i_res_jump))
        else $error("result changed while stalled");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !(i_req_valid && i_req_ready && (i_req_type == mjd_pkg::REQ_LOAD)))
        else $error("load taken while a result is pending");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_type == mjd_pkg::REQ_LOAD) |=> !i_res_valid)
        else $error("result appeared after a load on an empty pipeline");
endmodule

bind mlp_jump_decision_unit mjd_checker u_mjd_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_req_valid(i_req.valid),
    .i_req_ready(i_req.ready),
    .i_req_type(i_req.req_type),
    .i_res_valid(o_res.valid),
    .i_res_ready(o_res.ready),
    .i_res_jump(o_res.jump),
    .i_res_activation(o_res.activation)
);
`default_nettype wire
